/* hw/rtl/sbsd_pkg.sv */
// Shared types and constants for the SBUS steering decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sbsd_pkg;

    // Frame layout and channel widths.
    localparam int WIN_LEN = 24;
    localparam int CH_W    = 11;
    localparam int NUM_W   = 15;
    localparam int RECIP_W = 17;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QUOT_W  = 8;

    localparam logic [7:0] HDR_BYTE      = 8'h0F;
    localparam logic [7:0] FOOTER_BYTE   = 8'h00;
    localparam logic [7:0] FLAG_FAILSAFE = 8'h08;
    localparam logic [7:0] FLAG_LOST     = 8'h04;

    // Steering limits and servo pulse end points, in microseconds.
    localparam logic [CH_W-1:0] ST_MIN       = 11'd310;
    localparam logic [CH_W-1:0] ST_DEAD_LO   = 11'd1035;
    localparam logic [CH_W-1:0] ST_DEAD_HI   = 11'd1045;
    localparam logic [CH_W-1:0] ST_MAX       = 11'd1740;
    localparam logic [CH_W-1:0] PULSE_CENTER = 11'd1520;
    localparam logic [CH_W-1:0] PULSE_LEFT   = 11'd1300;
    localparam logic [CH_W-1:0] PULSE_RIGHT  = 11'd1740;

    // Both ranges scale by 220 / span; 220 / 695 = 44 / 139 and 220 / 725 = 44 / 145.
    // The reciprocals below are ceil(2^24 / 139) and ceil(2^24 / 145); with a
    // numerator below 2^15 the shifted product equals the truncated quotient.
    localparam int                 RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_LEFT  = 17'd120700;
    localparam logic [RECIP_W-1:0] RECIP_RIGHT = 17'd115705;

    // Steering region codes.
    typedef logic [1:0] region_t;
    localparam region_t REGION_DEAD  = 2'd0;
    localparam region_t REGION_LEFT  = 2'd1;
    localparam region_t REGION_RIGHT = 2'd2;

    // Item after frame check and channel extraction.
    typedef struct packed {
        logic              ok;
        logic              in_lim;
        region_t           region;
        logic [CH_W-1:0]   steer;
        logic [CH_W-1:0]   thr;
        logic [NUM_W-1:0]  num;
    } s1_t;

    // Item after the pulse mapping.
    typedef struct packed {
        logic            ok;
        logic            in_lim;
        logic [CH_W-1:0] steer;
        logic [CH_W-1:0] thr;
        logic [CH_W-1:0] pulse;
    } s2_t;

endpackage

`default_nettype wire

/* hw/rtl/sbsd_byte_cell.sv */
// One cell of the received byte window: holds one byte and takes its
// neighbor's byte on every shift. Depends on sbsd_pkg for nothing but style.
`timescale 1ns / 1ps
`default_nettype none

module sbsd_byte_cell
    import sbsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,
    input  wire logic [7:0] d_in,
    output logic      [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbor's byte when an item enters the window.
    always_comb
    begin
        byte_next = shift ? d_in : byte_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

`default_nettype wire

/* hw/rtl/sbsd_pulse_map.sv */
// Pulse mapping stage: scales the steering offset by a constant reciprocal
// and registers the servo pulse. Depends on sbsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsd_pulse_map
    import sbsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic load,
    input  wire s1_t  s1,
    output s2_t       s2
);

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot;
    logic [CH_W-1:0]    pulse;
    s2_t                s2_reg;
    s2_t                s2_next;

    // Truncating division by the span through a reciprocal multiply.
    always_comb
    begin
        recip = (s1.region == REGION_LEFT) ? RECIP_LEFT : RECIP_RIGHT;
        prod  = {{RECIP_W{1'b0}}, s1.num} * {{NUM_W{1'b0}}, recip};
        quot  = prod[PROD_W-1:RECIP_SHIFT];
    end

    // Pick the pulse by steering region.
    always_comb
    begin
        case (s1.region)
            REGION_DEAD:  pulse = PULSE_CENTER;
            REGION_LEFT:  pulse = PULSE_CENTER - {{(CH_W-QUOT_W){1'b0}}, quot};
            REGION_RIGHT: pulse = PULSE_RIGHT - {{(CH_W-QUOT_W){1'b0}}, quot};
            default:      pulse = PULSE_CENTER;
        endcase
    end

    always_comb
    begin
        s2_next.ok     = s1.ok;
        s2_next.in_lim = s1.in_lim;
        s2_next.steer  = s1.steer;
        s2_next.thr    = s1.thr;
        s2_next.pulse  = pulse;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;

endmodule

`default_nettype wire

/* hw/rtl/sbus_steering_decoder_unit.sv */
// Top level of the SBUS steering decoder: byte window chain, frame check,
// pulse mapping and output stage. Depends on sbsd_pkg, sbsd_byte_cell, sbsd_pulse_map.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one SBUS byte per item and returns one result per item, at
// a sustained rate of one item per clock cycle while out_ready stays high; the
// result is offered from the output register, after the frame check and pulse map registers.
// The rate is set by the 24-cell byte window, which shifts once per accepted
// item, and by the three-stage pipeline behind it (frame check, reciprocal
// multiply, output register); each stage holds its item independently, so a
// stalled output fills at most three stages before rx input is held off. A
// frame is accepted when the byte 24 items back is 0x0F, the new byte is 0x00
// and the flags byte has neither failsafe nor frame lost set. steering_raw,
// throttle_raw and steering_pulse hold the values of the last accepted frame;
// the pulse also holds when steering lies outside 310..1740. After reset the
// pulse reads 1520 and both raw channels read zero.
module sbus_steering_decoder_unit
    import sbsd_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [7:0]      rx_byte,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic                 frame_ok,
    output logic [CH_W-1:0]      steering_raw,
    output logic [CH_W-1:0]      throttle_raw,
    output logic [CH_W-1:0]      steering_pulse
);

    logic [7:0]      win [0:WIN_LEN-1];
    logic            in_acc;
    logic            adv2;
    logic            adv3;
    logic            load2;
    logic            load3;
    logic            v1_reg;
    logic            v1_next;
    logic            v2_reg;
    logic            v2_next;
    logic            v3_reg;
    logic            v3_next;
    s1_t             s1_reg;
    s1_t             s1_next;
    s2_t             s2;
    logic            ok_reg;
    logic            ok_next;
    logic [CH_W-1:0] steer_reg;
    logic [CH_W-1:0] steer_next;
    logic [CH_W-1:0] thr_reg;
    logic [CH_W-1:0] thr_next;
    logic [CH_W-1:0] pulse_reg;
    logic [CH_W-1:0] pulse_next;
    logic [CH_W-1:0] diff;

    // Per-stage flow control: a stage moves on when the next one is free or moving.
    assign adv3     = !v3_reg || out_ready;
    assign adv2     = !v2_reg || adv3;
    assign in_ready = !v1_reg || adv2;
    assign in_acc   = in_valid && in_ready;
    assign load2    = v1_reg && adv2;
    assign load3    = v2_reg && adv3;

    // Byte window: cell 0 holds the oldest byte, the last cell the previous byte.
    genvar i;
    generate
        for (i = 0; i < WIN_LEN; i++)
        begin : g_cell
            if (i == WIN_LEN - 1)
            begin : g_last
                sbsd_byte_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (in_acc),
                    .d_in  (rx_byte),
                    .q     (win[i])
                );
            end
            else
            begin : g_mid
                sbsd_byte_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (in_acc),
                    .d_in  (win[i+1]),
                    .q     (win[i])
                );
            end
        end
    endgenerate

    // Frame check, channel extraction and steering offset, from the window
    // as it stands before the new byte is shifted in.
    always_comb
    begin
        s1_next.ok = (win[0] == HDR_BYTE) && (rx_byte == FOOTER_BYTE) &&
                     ((win[WIN_LEN-1] & (FLAG_FAILSAFE | FLAG_LOST)) == 8'h00);
        s1_next.steer  = {win[2][2:0], win[1]};
        s1_next.thr    = {win[3][5:0], win[2][7:3]};
        s1_next.in_lim = (s1_next.steer >= ST_MIN) && (s1_next.steer <= ST_MAX);
        if (s1_next.steer > ST_DEAD_HI)
        begin
            s1_next.region = REGION_LEFT;
            diff           = s1_next.steer - ST_DEAD_HI;
        end
        else if (s1_next.steer >= ST_DEAD_LO)
        begin
            s1_next.region = REGION_DEAD;
            diff           = '0;
        end
        else
        begin
            s1_next.region = REGION_RIGHT;
            diff           = s1_next.steer - ST_MIN;
        end
        // Offset times 44, built from shifts.
        s1_next.num = NUM_W'({4'b0, diff} << 5) + NUM_W'({4'b0, diff} << 3) +
                      NUM_W'({4'b0, diff} << 2);
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
    end

    sbsd_pulse_map u_map (
        .clk  (clk),
        .load (load2),
        .s1   (s1_reg),
        .s2   (s2)
    );

    // Output stage; the held channel and pulse values live here.
    always_comb
    begin
        ok_next    = ok_reg;
        steer_next = steer_reg;
        thr_next   = thr_reg;
        pulse_next = pulse_reg;
        if (load3)
        begin
            ok_next = s2.ok;
            if (s2.ok)
            begin
                steer_next = s2.steer;
                thr_next   = s2.thr;
                if (s2.in_lim)
                begin
                    pulse_next = s2.pulse;
                end
            end
        end
    end

    // Stage valid bits.
    always_comb
    begin
        v1_next = in_acc ? 1'b1 : (load2 ? 1'b0 : v1_reg);
        v2_next = load2 ? 1'b1 : (load3 ? 1'b0 : v2_reg);
        v3_next = load3 ? 1'b1 : ((v3_reg && out_ready) ? 1'b0 : v3_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            ok_reg    <= 1'b0;
            steer_reg <= '0;
            thr_reg   <= '0;
            pulse_reg <= PULSE_CENTER;
        end
        else
        begin
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            v3_reg    <= v3_next;
            ok_reg    <= ok_next;
            steer_reg <= steer_next;
            thr_reg   <= thr_next;
            pulse_reg <= pulse_next;
        end
    end

    assign out_valid      = v3_reg;
    assign frame_ok       = ok_reg;
    assign steering_raw   = steer_reg;
    assign throttle_raw   = thr_reg;
    assign steering_pulse = pulse_reg;

    // The held pulse never leaves the servo range.
    a_pulse_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pulse_reg >= PULSE_LEFT) && (pulse_reg <= PULSE_RIGHT))
        else $error("steering pulse outside servo range");

    // Input is held off only when every pipeline stage is occupied.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg))
        else $error("input stalled with a free pipeline stage");

    // A rejected frame leaves the held channel values untouched.
    a_hold_raw: assert property (@(posedge clk) disable iff (!rst_n)
        (load3 && !s2.ok) |=> ($stable(steer_reg) && $stable(thr_reg)))
        else $error("held channels changed on a rejected frame");

endmodule

`default_nettype wire
